// ===== hdl/gbm_pkg.sv =====
// Shared constants for the geometric Brownian motion step block.
// Used by gbm_mul, gbm_isqrt, gbm_sdiv and gbm_path_step; depends on nothing.
package gbm_pkg;

    // Field widths.
    localparam int VAL_W    = 48;
    localparam int TIME_W   = 32;
    localparam int DRIFT_W  = 32;
    localparam int VOL_W    = 31;
    localparam int SAMPLE_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL   = 2'd1;

    // Shared multiplier: 64 x 64 operands built from 32 x 32 partial products.
    localparam int OPND_W = 64;
    localparam int HALF_W = 32;
    localparam int PROD_W = 128;

    // Square root of dt: 56-bit radicand (dt in Q.24), 28-bit root (Q.12).
    localparam int RAD_W  = 56;
    localparam int ROOT_W = 28;

    // Series divider: divisor covers term indexes up to SERIES_TERMS.
    localparam int SERIES_TERMS = 20;
    localparam int DIV_W        = 5;
    localparam int DIV_BITS     = 8;   // quotient bits resolved per cycle

    // Range reduction by ln 2.
    localparam int U_W = 41;
    localparam int Q_W = 8;
    localparam logic [31:0]    LN2_Q32  = 32'd2977044472;
    localparam logic [Q_W-1:0] K_OFFSET = 8'd93;
    localparam logic [Q_W-1:0] K_SPLIT  = 8'd155;   // quotient at which k equals 62
    localparam logic [U_W-1:0] U_BIAS   = 41'(64'(LN2_Q32) * 64'(K_OFFSET));

    // Exponent limit, 64 in Q.32, and the exponent word width.
    localparam int E_W = 48;
    localparam logic signed [E_W-1:0] EXP_LIM = 48'sh0040_0000_0000;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

endpackage

// ===== hdl/gbm_mul.sv =====
// Shared 64 x 64 multiplier: one 32 x 32 partial product per cycle, accumulated.
// Depends on gbm_pkg.
module gbm_mul
    import gbm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [OPND_W-1:0] op_a,
    input  logic [OPND_W-1:0] op_b,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic [OPND_W-1:0] a_reg, b_reg;
    logic [1:0]        cnt_reg;
    logic              run_reg;
    logic [OPND_W-1:0] pp_reg;
    logic [1:0]        pp_idx_reg;
    logic              pp_vld_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              done_reg;
    logic [HALF_W-1:0] a_half, b_half;
    logic [PROD_W-1:0] pp_shifted;

    // Pick the operand halves for the current partial product.
    assign a_half = cnt_reg[1] ? a_reg[OPND_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_half = cnt_reg[0] ? b_reg[OPND_W-1:HALF_W] : b_reg[HALF_W-1:0];

    // Weight of a partial product follows the sum of its half indexes.
    always_comb begin
        case (pp_idx_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd3:    pp_shifted = PROD_W'(pp_reg) << (2 * HALF_W);
            default: pp_shifted = PROD_W'(pp_reg) << HALF_W;
        endcase
    end

    // Issue partial products into a register, then accumulate them in the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= 1'b0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            done_reg   <= pp_vld_reg && (pp_idx_reg == 2'd3);
            pp_vld_reg <= run_reg;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (pp_vld_reg) begin
            acc_reg <= acc_reg + pp_shifted;
        end
        pp_reg     <= OPND_W'(a_half) * OPND_W'(b_half);
        pp_idx_reg <= cnt_reg;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hdl/gbm_isqrt.sv =====
// Integer square root, two radicand bits per cycle (digit by digit).
// Depends on gbm_pkg.
module gbm_isqrt
    import gbm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    // One restoring step: bring down two bits and try root*4+1.
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(ROOT_W - 1);
        end else if (run_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= REM_W'(ge ? rem_sh - trial : rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/gbm_sdiv.sv =====
// Divider of a 64-bit value by a small divisor, eight quotient bits per cycle.
// Depends on gbm_pkg.
module gbm_sdiv
    import gbm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [OPND_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [OPND_W-1:0] quotient
);

    localparam int STEPS = OPND_W / DIV_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [OPND_W-1:0] quo_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [OPND_W-1:0] quo_next;
    logic [DIV_W-1:0]  rem_next;

    // Eight narrow restoring steps; the remainder stays below the divisor.
    always_comb begin
        logic [DIV_W:0] r6;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int j = 0; j < DIV_BITS; j++) begin
            r6       = {rem_next, quo_next[OPND_W-1]};
            quo_next = quo_next << 1;
            if (r6 >= {1'b0, dsr_reg}) begin
                r6          = r6 - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = r6[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(STEPS - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/gbm_path_step.sv =====
// Top level of the geometric Brownian motion step block; one beat in, one beat out.
// Depends on gbm_pkg, gbm_mul, gbm_isqrt and gbm_sdiv.
//
// A start beat, or a step whose time point lies before the stored one, is answered
// in the cycle after it is taken. A regular step runs a small sequencer over one
// shared 64 x 64 multiplier (four 32 x 32 partial products each): drift term,
// volatility squared, variance term, volatility times sqrt(dt) and the diffusion
// term, a reduction by ln 2 of eight quotient bits, then twenty series terms of one
// product and one division each, a final product and a rounded scale. The square
// root of dt runs in its own unit, started at the accept, and the volatility product
// waits for it. A zero value or an exponent out of range skips the reduction, the
// series and the scale; the series loop dominates a step. The input is not ready
// while a step is in progress or while a result waits.
module gbm_path_step
    import gbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_start_req,
    input  logic [VAL_W-1:0]      s_initial_value,
    input  logic [TIME_W-1:0]     s_time_point,
    input  logic signed [SAMPLE_W-1:0] s_normal_sample,
    // Result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VAL_W-1:0]      m_path_value,
    output logic                  m_saturated,
    output logic                  m_bad_time
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_A    = 4'd1;
    localparam logic [3:0] ST_V2   = 4'd2;
    localparam logic [3:0] ST_B    = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_VQ   = 4'd5;
    localparam logic [3:0] ST_C    = 4'd6;
    localparam logic [3:0] ST_E    = 4'd7;
    localparam logic [3:0] ST_K    = 4'd8;
    localparam logic [3:0] ST_TM   = 4'd9;
    localparam logic [3:0] ST_TD   = 4'd10;
    localparam logic [3:0] ST_XM   = 4'd11;
    localparam logic [3:0] ST_SH   = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    localparam logic [OPND_W-1:0] ONE_Q62 = OPND_W'(1) << 62;

    // Round half up of a product divided by 2^s.
    function automatic logic [PROD_W-1:0] rnd_shr(input logic [PROD_W-1:0] p,
                                                  input int unsigned s);
        rnd_shr = (p + (PROD_W'(1) << (s - 1))) >> s;
    endfunction

    logic [3:0]          state_reg;
    logic [DRIFT_W-1:0]  drift_reg;
    logic [VOL_W-1:0]    vol_reg;
    logic [VAL_W-1:0]    cur_reg;
    logic [TIME_W-1:0]   prev_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic                mu_neg_reg, z_neg_reg;
    logic [SAMPLE_W-1:0] zmag_reg;
    logic [44:0]         a_reg;
    logic [45:0]         b_reg;
    logic [42:0]         c_reg;
    logic [U_W-1:0]      krem_reg;
    logic [Q_W-1:0]      qk_reg;
    logic [2:0]          kcnt_reg;
    logic                kbig_reg;
    logic [Q_W-1:0]      shamt_reg;
    logic [31:0]         r_reg;
    logic [OPND_W-1:0]   sum_reg;
    logic [DIV_W-1:0]    n_reg;
    logic [PROD_W-1:0]   big_reg;
    logic [VAL_W-1:0]    res_reg;
    logic                res_sat_reg;
    logic                mul_start_reg;
    logic [OPND_W-1:0]   mul_a_reg, mul_b_reg;
    logic                div_start_reg;
    logic [OPND_W-1:0]   div_a_reg;
    logic                sq_start_reg;
    logic [RAD_W-1:0]    sq_rad_reg;
    logic                m_valid_reg;
    logic [VAL_W-1:0]    m_val_reg;
    logic                m_sat_reg, m_bad_reg;

    logic                mul_done, div_done, sq_done;
    logic [PROD_W-1:0]   mul_prod;
    logic [OPND_W-1:0]   div_quot;
    logic [ROOT_W-1:0]   sq_root;
    logic                out_free, in_acc;
    logic                step_acc, mul_issue, div_issue, out_load;
    logic [TIME_W-1:0]   dt_in;
    logic [DRIFT_W-1:0]  mu_mag;
    logic [SAMPLE_W-1:0] z_mag;
    logic signed [E_W-1:0] a_x, b_x, c_x, e_val;
    logic [U_W-1:0]      dshift, krem_next;
    logic                kge;
    logic [Q_W-1:0]      qk_next;
    logic [PROD_W-1:0]   r20, r32, r49;
    logic [OPND_W-1:0]   sum_next;
    logic [PROD_W-1:0]   scaled;

    gbm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    gbm_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start_reg),
        .radicand (sq_rad_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    gbm_sdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Handshakes: the result register may be refilled in the cycle it drains.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_acc    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // A regular step starts the multiplier and the square root; every other beat is answered at once.
    assign step_acc  = in_acc && !s_start_req && !(s_time_point < prev_reg);
    assign out_load  = (in_acc && !step_acc) || ((state_reg == ST_OUT) && out_free);
    assign div_issue = (state_reg == ST_TM) && mul_done;

    // Multiplier issue points of the sequencer.
    always_comb begin
        case (state_reg)
            ST_IDLE:            mul_issue = step_acc;
            ST_A, ST_V2, ST_VQ: mul_issue = mul_done;
            ST_SQ:              mul_issue = sq_done;
            ST_K:               mul_issue = (kcnt_reg == 3'd0);
            ST_TD:              mul_issue = div_done;
            default:            mul_issue = 1'b0;
        endcase
    end

    // Operand magnitudes and the time step.
    assign dt_in  = s_time_point - prev_reg;
    assign mu_mag = drift_reg[DRIFT_W-1] ? (~drift_reg + 1'b1) : drift_reg;
    assign z_mag  = s_normal_sample[SAMPLE_W-1] ? SAMPLE_W'(-s_normal_sample)
                                                : SAMPLE_W'(s_normal_sample);

    // Rounded views of the multiplier result.
    assign r20 = rnd_shr(mul_prod, 20);
    assign r32 = rnd_shr(mul_prod, 32);
    assign r49 = rnd_shr(mul_prod, 49);

    // Summed exponent in Q.32.
    assign a_x   = $signed(E_W'(a_reg));
    assign b_x   = $signed(E_W'(b_reg));
    assign c_x   = $signed(E_W'(c_reg));
    assign e_val = (mu_neg_reg ? -a_x : a_x) - b_x + (z_neg_reg ? -c_x : c_x);

    // One quotient bit of the reduction by ln 2.
    assign dshift    = U_W'(LN2_Q32) << kcnt_reg;
    assign kge       = krem_reg >= dshift;
    assign krem_next = kge ? krem_reg - dshift : krem_reg;
    assign qk_next   = {qk_reg[Q_W-2:0], kge};

    assign sum_next = sum_reg + div_quot;

    // Scale down with rounding, or up exactly for large k.
    assign scaled = kbig_reg ? (big_reg >> (Q_W'(VAL_W) - shamt_reg))
                             : (big_reg >> shamt_reg);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drift_reg <= '0;
            vol_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DRIFT: drift_reg <= cfg_data;
                CFG_VOL:   vol_reg   <= cfg_data[VOL_W-1:0];
                default:   ;
            endcase
        end
    end

    // Sequencer and process state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            prev_reg      <= '0;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
        end else begin
            mul_start_reg <= mul_issue;
            div_start_reg <= div_issue;
            sq_start_reg  <= step_acc;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_start_req) begin
                            cur_reg     <= s_initial_value;
                            prev_reg    <= s_time_point;
                            m_val_reg   <= s_initial_value;
                            m_sat_reg   <= 1'b0;
                            m_bad_reg   <= 1'b0;
                        end else if (s_time_point < prev_reg) begin
                            m_val_reg   <= cur_reg;
                            m_sat_reg   <= 1'b0;
                            m_bad_reg   <= 1'b1;
                        end else begin
                            prev_reg      <= s_time_point;
                            dt_reg        <= dt_in;
                            mu_neg_reg    <= drift_reg[DRIFT_W-1];
                            z_neg_reg     <= s_normal_sample[SAMPLE_W-1];
                            zmag_reg      <= z_mag;
                            sq_rad_reg    <= {dt_in, 24'd0};
                            mul_a_reg     <= OPND_W'(mu_mag);
                            mul_b_reg     <= OPND_W'(dt_in);
                            state_reg     <= ST_A;
                        end
                    end
                end
                ST_A: begin
                    if (mul_done) begin
                        a_reg         <= r20[44:0];
                        mul_a_reg     <= OPND_W'(vol_reg);
                        mul_b_reg     <= OPND_W'(vol_reg);
                        state_reg     <= ST_V2;
                    end
                end
                ST_V2: begin
                    if (mul_done) begin
                        mul_a_reg     <= mul_prod[OPND_W-1:0];
                        mul_b_reg     <= OPND_W'(dt_reg);
                        state_reg     <= ST_B;
                    end
                end
                ST_B: begin
                    if (mul_done) begin
                        b_reg     <= r49[45:0];
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (sq_done) begin
                        mul_a_reg     <= OPND_W'(vol_reg);
                        mul_b_reg     <= OPND_W'(sq_root);
                        state_reg     <= ST_VQ;
                    end
                end
                ST_VQ: begin
                    if (mul_done) begin
                        mul_a_reg     <= mul_prod[OPND_W-1:0];
                        mul_b_reg     <= OPND_W'(zmag_reg);
                        state_reg     <= ST_C;
                    end
                end
                ST_C: begin
                    if (mul_done) begin
                        c_reg     <= r32[42:0];
                        state_reg <= ST_E;
                    end
                end
                ST_E: begin
                    // Zero value, and exponents out of range, skip the series.
                    if (cur_reg == '0) begin
                        res_reg     <= '0;
                        res_sat_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end else if (e_val > EXP_LIM) begin
                        res_reg     <= VAL_MAX;
                        res_sat_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end else if (e_val < -EXP_LIM) begin
                        res_reg     <= '0;
                        res_sat_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end else begin
                        krem_reg  <= U_W'(e_val) + U_BIAS;
                        qk_reg    <= '0;
                        kcnt_reg  <= 3'd7;
                        state_reg <= ST_K;
                    end
                end
                ST_K: begin
                    krem_reg <= krem_next;
                    qk_reg   <= qk_next;
                    kcnt_reg <= kcnt_reg - 3'd1;
                    if (kcnt_reg == 3'd0) begin
                        kbig_reg      <= qk_next > K_SPLIT;
                        shamt_reg     <= (qk_next > K_SPLIT) ? qk_next - K_SPLIT
                                                             : K_SPLIT - qk_next;
                        r_reg         <= krem_next[31:0];
                        sum_reg       <= ONE_Q62;
                        n_reg         <= DIV_W'(1);
                        mul_a_reg     <= ONE_Q62;
                        mul_b_reg     <= OPND_W'(krem_next[31:0]);
                        state_reg     <= ST_TM;
                    end
                end
                ST_TM: begin
                    if (mul_done) begin
                        div_a_reg     <= r32[OPND_W-1:0];
                        state_reg     <= ST_TD;
                    end
                end
                ST_TD: begin
                    if (div_done) begin
                        sum_reg       <= sum_next;
                        if (n_reg == DIV_W'(SERIES_TERMS)) begin
                            mul_a_reg <= OPND_W'(cur_reg);
                            mul_b_reg <= sum_next;
                            state_reg <= ST_XM;
                        end else begin
                            n_reg     <= n_reg + 1'b1;
                            mul_a_reg <= div_quot;
                            mul_b_reg <= OPND_W'(r_reg);
                            state_reg <= ST_TM;
                        end
                    end
                end
                ST_XM: begin
                    if (mul_done) begin
                        if (kbig_reg || shamt_reg == '0) begin
                            big_reg <= mul_prod;
                        end else begin
                            big_reg <= mul_prod + (PROD_W'(1) << (shamt_reg - 1'b1));
                        end
                        state_reg <= ST_SH;
                    end
                end
                ST_SH: begin
                    if (scaled[PROD_W-1:VAL_W] != '0 || (kbig_reg && scaled[VAL_W-1:0] != '0))
                    begin
                        res_reg     <= VAL_MAX;
                        res_sat_reg <= 1'b1;
                    end else begin
                        res_reg     <= kbig_reg ? VAL_W'(big_reg[VAL_W-1:0] << shamt_reg)
                                                : scaled[VAL_W-1:0];
                        res_sat_reg <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        cur_reg     <= res_reg;
                        m_val_reg   <= res_reg;
                        m_sat_reg   <= res_sat_reg;
                        m_bad_reg   <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_path_value = m_val_reg;
    assign m_saturated  = m_sat_reg;
    assign m_bad_time   = m_bad_reg;

endmodule
